// ----- rtl/chtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtd_pkg: shared types and codes of the canonical Huffman table decoder
// Holds the operation and status codes and the command and status records
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package chtd_pkg;

	localparam logic [1:0] F_ENTRY  = 2'd0;
	localparam logic [1:0] F_BIT    = 2'd1;
	localparam logic [1:0] F_END    = 2'd2;
	localparam logic [1:0] F_UNUSED = 2'd3;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_BAD_LEN     = 4'd1;
	localparam logic [3:0] ST_OVERSUB     = 4'd2;
	localparam logic [3:0] ST_INCOMPLETE  = 4'd3;
	localparam logic [3:0] ST_SYMBOL      = 4'd4;
	localparam logic [3:0] ST_UNDEF       = 4'd5;
	localparam logic [3:0] ST_OUT_OF_BITS = 4'd6;
	localparam logic [3:0] ST_NO_TABLE    = 4'd7;
	localparam logic [3:0] ST_TOO_MANY    = 4'd8;

	typedef struct packed {
		logic       load;
		logic       bit_step;
		logic       walk_clr;
		logic       chk_init;
		logic       chk_step;
		logic       off_init;
		logic       off_step;
		logic       sort_init;
		logic       sort_step;
		logic       fin;
		logic       fin_ok;
		logic       res_load;
		logic [3:0] res_code;
		logic       res_mem;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic       walk_end;
		logic       no_table;
		logic       partial;
		logic [1:0] bad;
		logic       zero_tab;
		logic       room_neg;
		logic       room_pos;
		logic       used_one;
		logic       it_last;
		logic       sort_last;
	} sts_t;

endpackage

// ----- rtl/chtd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtd_if: item channels of the canonical Huffman table decoder
// Input and result channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface chtd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] code_length;
	logic       last_entry;
	logic       code_bit;

	modport source (output valid, output func, output code_length, output last_entry,
		output code_bit, input ready);
	modport sink (input valid, input func, input code_length, input last_entry,
		input code_bit, output ready);
endinterface

interface chtd_out_if;
	logic       valid;
	logic       ready;
	logic [3:0] status;
	logic [8:0] symbol;
	logic [3:0] bits_used;

	modport source (output valid, output status, output symbol, output bits_used,
		input ready);
	modport sink (input valid, input status, input symbol, input bits_used,
		output ready);
endinterface

// ----- rtl/canonical_huffman_table_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_table_decoder: canonical Huffman table loader and decoder
// Loads a table of code lengths, checks and sorts it, then decodes code bits
// one at a time by the canonical first/count walk.
// ----------------------------------------------------------------------------
// Code-length entries give no result, apart from the closing entry, which
// starts the table build: a check of the entry flags, the code-space check
// over every code length, the offset computation, a sweep of the loaded
// entries through the length memory and a drain step, then the status item.
// A rejected table, or one with no used length, ends the build early. A code
// bit that gives no result is taken in idle; one that gives a result passes
// through the hand-off state, which moves the registered symbol memory read
// into the output register. The block waits in its hand-off state only
// while that output register still holds an item nobody has taken.
module canonical_huffman_table_decoder #(
	parameter int MAX_CODE_BITS = 15,
	parameter int MAX_SYMBOLS   = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	chtd_in_if.sink   in_item,
	chtd_out_if.source out_item
);
	import chtd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller decides on each item and sequences the build passes.
	chtd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_item.valid),
		.func       (in_item.func),
		.last_entry (in_item.last_entry),
		.in_ready   (in_item.ready),
		.out_ready  (out_item.ready),
		.out_valid  (out_item.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	// The datapath holds the table, the walk and the result register.
	chtd_dp #(
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.MAX_SYMBOLS   (MAX_SYMBOLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.code_length (in_item.code_length),
		.code_bit    (in_item.code_bit),
		.status      (out_item.status),
		.symbol      (out_item.symbol),
		.bits_used   (out_item.bits_used)
	);

endmodule

// ----- rtl/chtd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtd_ctrl: controller of the canonical Huffman table decoder
// Sequences item acceptance, the table build passes and the result hand-off.
// ----------------------------------------------------------------------------
module chtd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      func,
	input  logic            last_entry,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	input  chtd_pkg::sts_t  sts,
	output chtd_pkg::cmd_t  cmd
);
	import chtd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PRE   = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_OFF   = 3'd3;
	localparam logic [2:0] S_SORT  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (func)
						F_ENTRY: begin
							cmd.load = 1'b1;
							if (last_entry) state_d = S_PRE;
						end
						F_BIT: begin
							if (sts.no_table) begin
								cmd.res_load = 1'b1;
								cmd.res_code = ST_NO_TABLE;
								state_d      = S_EMIT;
							end else begin
								cmd.bit_step = 1'b1;
								if (sts.hit) begin
									cmd.res_load = 1'b1;
									cmd.res_code = ST_SYMBOL;
									cmd.res_mem  = 1'b1;
									state_d      = S_EMIT;
								end else if (sts.walk_end) begin
									cmd.res_load = 1'b1;
									cmd.res_code = ST_UNDEF;
									state_d      = S_EMIT;
								end
							end
						end
						F_END: begin
							if (sts.partial) begin
								cmd.walk_clr = 1'b1;
								cmd.res_load = 1'b1;
								cmd.res_code = ST_OUT_OF_BITS;
								state_d      = S_EMIT;
							end
						end
						default: ;
					endcase
				end
			end
			S_PRE: begin
				cmd.fin      = 1'b1;
				cmd.res_load = 1'b1;
				state_d      = S_EMIT;
				if (sts.bad[1]) begin
					cmd.res_code = ST_TOO_MANY;
				end else if (sts.bad[0]) begin
					cmd.res_code = ST_BAD_LEN;
				end else if (sts.zero_tab) begin
					cmd.res_code = ST_OK;
					cmd.fin_ok   = 1'b1;
				end else begin
					cmd.fin      = 1'b0;
					cmd.res_load = 1'b0;
					cmd.chk_init = 1'b1;
					state_d      = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.room_neg) begin
					cmd.fin      = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_code = ST_OVERSUB;
					state_d      = S_EMIT;
				end else if (sts.it_last) begin
					if (sts.room_pos && !sts.used_one) begin
						cmd.fin      = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_code = ST_INCOMPLETE;
						state_d      = S_EMIT;
					end else begin
						cmd.off_init = 1'b1;
						state_d      = S_OFF;
					end
				end else begin
					cmd.chk_step = 1'b1;
				end
			end
			S_OFF: begin
				cmd.off_step = 1'b1;
				if (sts.it_last) begin
					cmd.sort_init = 1'b1;
					state_d       = S_SORT;
				end
			end
			S_SORT: begin
				cmd.sort_step = 1'b1;
				if (sts.sort_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				cmd.fin      = 1'b1;
				cmd.fin_ok   = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_code = ST_OK;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/chtd_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtd_dp: datapath of the canonical Huffman table decoder
// Length and symbol memories, length counts, build iterators, decode walk
// and the result register.
// ----------------------------------------------------------------------------
module chtd_dp #(
	parameter int MAX_CODE_BITS = 15,
	parameter int MAX_SYMBOLS   = 512
) (
	input  logic            clk,
	input  logic            arst_n,
	input  chtd_pkg::cmd_t  cmd,
	output chtd_pkg::sts_t  sts,
	input  logic [7:0]      code_length,
	input  logic            code_bit,
	output logic [3:0]      status,
	output logic [8:0]      symbol,
	output logic [3:0]      bits_used
);
	import chtd_pkg::*;

	localparam int LW = $clog2(MAX_CODE_BITS + 1);
	localparam int EW = $clog2(MAX_SYMBOLS + 1);
	localparam int SA = $clog2(MAX_SYMBOLS);
	localparam int CW = MAX_CODE_BITS + 2;
	localparam int MW = (CW > EW) ? CW : EW;
	localparam int RW = (MAX_CODE_BITS + 3 > EW + 2) ? MAX_CODE_BITS + 3 : EW + 2;

	logic [LW-1:0] len_mem [MAX_SYMBOLS];
	logic [SA-1:0] sym_mem [MAX_SYMBOLS];
	logic [EW-1:0] cnt_q [MAX_CODE_BITS+1];
	logic [EW-1:0] nxt_q [MAX_CODE_BITS+1];

	logic [EW-1:0]        ent_q;
	logic [1:0]           bad_q;
	logic                 valid_q;
	logic [CW-1:0]        part_q;
	logic [CW-1:0]        first_q;
	logic [EW-1:0]        base_q;
	logic [LW-1:0]        taken_q;
	logic [LW-1:0]        it_q;
	logic signed [RW-1:0] room_q;
	logic [EW-1:0]        acc_q;
	logic [EW-1:0]        s_q;
	logic                 sv_s1;
	logic [SA-1:0]        si_s1;
	logic [LW-1:0]        l_s1;
	logic [SA-1:0]        sym_rd_q;
	logic [3:0]           res_status_q;
	logic                 res_mem_q;
	logic [3:0]           res_bits_q;
	logic [3:0]           out_status_q;
	logic [8:0]           out_sym_q;
	logic [3:0]           out_bits_q;

	logic                 in_range;
	logic [LW-1:0]        clen_l;
	logic                 full;
	logic [LW-1:0]        len_w;
	logic [EW-1:0]        cnt_bit;
	logic [EW-1:0]        cnt_it;
	logic [CW-1:0]        pc;
	logic [CW-1:0]        diff;
	logic [EW-1:0]        idx;
	logic signed [RW-1:0] room_nx;
	logic [EW-1:0]        used;
	logic                 restart;

	assign in_range = (code_length <= 8'(MAX_CODE_BITS));
	assign clen_l   = code_length[LW-1:0];
	assign full     = (ent_q >= EW'(MAX_SYMBOLS));
	assign len_w    = taken_q + LW'(1);
	assign cnt_bit  = cnt_q[len_w];
	assign cnt_it   = cnt_q[it_q];
	assign pc       = part_q | CW'(code_bit);
	assign diff     = pc - first_q;
	assign idx      = base_q + EW'(diff);
	assign room_nx  = (room_q <<< 1) - $signed(RW'(cnt_it));
	assign used     = ent_q - cnt_q[0];

	assign sts.hit       = (pc >= first_q) && (MW'(diff) < MW'(cnt_bit));
	assign sts.walk_end  = (len_w == LW'(MAX_CODE_BITS));
	assign sts.no_table  = !valid_q || (ent_q != '0);
	assign sts.partial   = (taken_q != '0);
	assign sts.bad       = bad_q;
	assign sts.zero_tab  = (cnt_q[0] == ent_q);
	assign sts.room_neg  = (room_nx < 0);
	assign sts.room_pos  = (room_nx > 0);
	assign sts.used_one  = (used == EW'(1));
	assign sts.it_last   = (it_q == LW'(MAX_CODE_BITS));
	assign sts.sort_last = (s_q == ent_q - EW'(1));

	assign restart = cmd.walk_clr || cmd.fin || (cmd.load && ent_q == '0)
		|| (cmd.bit_step && (sts.hit || sts.walk_end));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= MAX_CODE_BITS; i++) cnt_q[i] <= '0;
			ent_q   <= '0;
			bad_q   <= '0;
			valid_q <= 1'b0;
			part_q  <= '0;
			first_q <= '0;
			base_q  <= '0;
			taken_q <= '0;
			it_q    <= '0;
			room_q  <= '0;
			acc_q   <= '0;
			s_q     <= '0;
			sv_s1   <= 1'b0;
		end else begin
			sv_s1 <= cmd.sort_step;
			if (cmd.load) begin
				if (ent_q == '0) valid_q <= 1'b0;
				// The first entry of a table restarts every count.
				for (int i = 0; i <= MAX_CODE_BITS; i++) begin
					if (!full && in_range && clen_l == LW'(i))
						cnt_q[i] <= (ent_q == '0) ? EW'(1) : cnt_q[i] + EW'(1);
					else if (ent_q == '0)
						cnt_q[i] <= '0;
				end
				bad_q <= ((ent_q == '0) ? 2'b00 : bad_q) | {full, !full && !in_range};
				if (!full) ent_q <= ent_q + EW'(1);
			end
			if (restart) begin
				part_q  <= '0;
				first_q <= '0;
				base_q  <= '0;
				taken_q <= '0;
			end else if (cmd.bit_step) begin
				base_q  <= base_q + cnt_bit;
				first_q <= (first_q + CW'(cnt_bit)) << 1;
				part_q  <= pc << 1;
				taken_q <= len_w;
			end
			if (cmd.fin) begin
				ent_q   <= '0;
				valid_q <= cmd.fin_ok;
			end
			if (cmd.chk_init || cmd.off_init) it_q <= LW'(1);
			else if (cmd.chk_step || cmd.off_step) it_q <= it_q + LW'(1);
			if (cmd.chk_init) room_q <= RW'(1);
			else if (cmd.chk_step) room_q <= room_nx;
			if (cmd.off_init) acc_q <= '0;
			else if (cmd.off_step) acc_q <= acc_q + cnt_it;
			if (cmd.sort_init) s_q <= '0;
			else if (cmd.sort_step) s_q <= s_q + EW'(1);
		end
	end

	// Length memory: written while loading, swept once by the sort pass.
	always_ff @(posedge clk) begin
		if (cmd.load && !full) len_mem[ent_q[SA-1:0]] <= clen_l;
		if (cmd.sort_step) begin
			l_s1  <= len_mem[s_q[SA-1:0]];
			si_s1 <= s_q[SA-1:0];
		end
	end

	// Symbol memory: filled in (length, symbol) order, read by the walk.
	always_ff @(posedge clk) begin
		if (sv_s1 && l_s1 != '0) sym_mem[nxt_q[l_s1][SA-1:0]] <= si_s1;
		if (cmd.bit_step) sym_rd_q <= sym_mem[idx[SA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.off_step) nxt_q[it_q] <= acc_q;
		if (sv_s1 && l_s1 != '0) nxt_q[l_s1] <= nxt_q[l_s1] + EW'(1);
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			res_mem_q    <= cmd.res_mem;
			res_bits_q   <= cmd.res_mem ? 4'(len_w) : 4'd0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_sym_q    <= res_mem_q ? 9'(sym_rd_q) : 9'd0;
			out_bits_q   <= res_bits_q;
		end
	end

	assign status    = out_status_q;
	assign symbol    = out_sym_q;
	assign bits_used = out_bits_q;

endmodule

// ----- rtl/chtd_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chtd_chk: port checker of the canonical Huffman table decoder
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module chtd_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] status,
	input logic [8:0] symbol,
	input logic [3:0] bits_used
);
	import chtd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(symbol)
		&& $stable(bits_used))
		else $error("result item changed while stalled");

	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_SYMBOL |-> symbol == 9'd0 && bits_used == 4'd0)
		else $error("non-symbol item carries symbol data");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_TOO_MANY)
		else $error("status code out of range");

endmodule

bind canonical_huffman_table_decoder chtd_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_item.valid),
	.out_ready (out_item.ready),
	.status    (out_item.status),
	.symbol    (out_item.symbol),
	.bits_used (out_item.bits_used)
);

// ----- test/canonical_huffman_table_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_table_decoder_test: self-checking bench of the decoder
// Loads code-length tables, good and broken, decodes random code bits
// through them and compares every result item with a built-in model of the
// table check, the canonical sort and the bit-serial walk.
// ----------------------------------------------------------------------------
module canonical_huffman_table_decoder_test;
	import chtd_pkg::*;

	localparam int MAX_BITS = 15;
	localparam int MAX_SYMS = 512;
	localparam int N_ITEMS  = 1450;
	localparam int LIMIT    = 2000000;
	localparam int DRAIN    = 700;

	typedef struct packed {
		logic [3:0] status;
		logic [8:0] symbol;
		logic [3:0] bits_used;
	} result_t;

	typedef struct {
		logic [1:0] func;
		logic [7:0] code_length;
		logic       last_entry;
		logic       code_bit;
		bit         typed;
		result_t    res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	chtd_in_if  in_item();
	chtd_out_if out_item();

	canonical_huffman_table_decoder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.out_item (out_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model state of the table loader and the decode walk.
	logic [7:0]  len_mem [MAX_SYMS];
	logic [8:0]  sym_mem [MAX_SYMS];
	int unsigned len_cnt [MAX_BITS + 1];
	int unsigned n_loaded;
	logic [1:0]  bad_flags;
	bit          table_ok;
	int unsigned code_acc, first_code, sym_base, taken;

	result_t     expected_results[$];
	int          mismatches = 0;
	int unsigned cycles = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          issued = 0;

	function automatic void walk_clear();
		code_acc = 0;
		first_code = 0;
		sym_base = 0;
		taken = 0;
	endfunction

	// Checks the loaded lengths and, when the code space is sound, places the
	// used symbols in (length, symbol) order.
	function automatic logic [3:0] check_and_sort();
		int room;
		int unsigned nxt [MAX_BITS + 2];
		int unsigned l;
		room = 1;
		if (bad_flags[1]) return ST_TOO_MANY;
		if (bad_flags[0]) return ST_BAD_LEN;
		if (len_cnt[0] == n_loaded) return ST_OK;
		for (int k = 1; k <= MAX_BITS; k++) begin
			room = room * 2 - int'(len_cnt[k]);
			if (room < 0) return ST_OVERSUB;
		end
		if (room > 0 && n_loaded - len_cnt[0] != 1) return ST_INCOMPLETE;
		nxt[1] = 0;
		for (int k = 1; k <= MAX_BITS; k++)
			nxt[k + 1] = nxt[k] + len_cnt[k];
		for (int s = 0; s < n_loaded && s < MAX_SYMS; s++) begin
			l = len_mem[s];
			if (l != 0 && l <= MAX_BITS) begin
				if (nxt[l] < MAX_SYMS) sym_mem[nxt[l]] = s[8:0];
				nxt[l]++;
			end
		end
		return ST_OK;
	endfunction

	// Advances the model by one accepted item; returns 1 when a result is due.
	function automatic bit decode_step(input logic [1:0] func, input logic [7:0] clen,
		input logic last, input logic cbit, output result_t res);
		int unsigned len, cnt, idx;
		res = '0;
		if (func == F_ENTRY) begin
			if (n_loaded == 0) begin
				foreach (len_cnt[k]) len_cnt[k] = 0;
				bad_flags = 2'b00;
				table_ok = 1'b0;
				walk_clear();
			end
			if (n_loaded >= MAX_SYMS) begin
				bad_flags[1] = 1'b1;
			end else begin
				len_mem[n_loaded] = clen;
				if (clen > MAX_BITS) bad_flags[0] = 1'b1;
				else len_cnt[clen]++;
				n_loaded++;
			end
			if (last) begin
				res.status = check_and_sort();
				table_ok = (res.status == ST_OK);
				n_loaded = 0;
				walk_clear();
				return 1'b1;
			end
			return 1'b0;
		end
		if (func == F_BIT) begin
			if (!table_ok || n_loaded != 0) begin
				res.status = ST_NO_TABLE;
				return 1'b1;
			end
			len = taken + 1;
			code_acc |= cbit;
			cnt = len_cnt[len];
			if (code_acc >= first_code && code_acc - first_code < cnt) begin
				idx = sym_base + code_acc - first_code;
				res.status = ST_SYMBOL;
				res.symbol = (idx < MAX_SYMS) ? sym_mem[idx] : 9'd0;
				res.bits_used = len[3:0];
				walk_clear();
				return 1'b1;
			end
			if (len >= MAX_BITS) begin
				walk_clear();
				res.status = ST_UNDEF;
				return 1'b1;
			end
			sym_base += cnt;
			first_code = ((first_code + cnt) << 1) & 32'h1FFFF;
			code_acc = (code_acc << 1) & 32'h1FFFF;
			taken = len;
			return 1'b0;
		end
		if (func == F_END && taken != 0) begin
			walk_clear();
			res.status = ST_OUT_OF_BITS;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Offers one item, idling first at the phase's rate, and waits until the
	// block takes it. The valid line is left high so that back-to-back items
	// see no bubble.
	task automatic send_item(input logic [1:0] func, input logic [7:0] clen,
		input logic last, input logic cbit, input bit typed, input result_t typed_res);
		result_t res;
		while ($urandom_range(99) < idle_pct) begin
			in_item.valid <= 1'b0;
			@(posedge clk);
		end
		in_item.valid <= 1'b1;
		in_item.func <= func;
		in_item.code_length <= clen;
		in_item.last_entry <= last;
		in_item.code_bit <= cbit;
		do @(posedge clk); while (!in_item.ready);
		if (decode_step(func, clen, last, cbit, res))
			expected_results.push_back(typed ? typed_res : res);
		if (func != F_UNUSED) issued++;
	endtask

	task automatic send(input logic [1:0] func, input logic [7:0] clen,
		input logic last, input logic cbit);
		send_item(func, clen, last, cbit, 1'b0, '0);
	endtask

	// The sender holds off until every outstanding result has been taken.
	task automatic drain();
		in_item.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Loads a table of n entries. With used above one the lengths form a
	// complete code, grown by splitting random leaves; a single used symbol
	// gets any legal length. A broken table has a few lengths disturbed.
	task automatic load_table(input int n, input int used, input bit broken);
		int depth[$];
		int lens[];
		int perm[];
		int pick, d, tmp;
		lens = new[n];
		perm = new[n];
		if (used == 1) begin
			depth.push_back($urandom_range(1, MAX_BITS));
		end else begin
			depth = '{1, 1};
			while (depth.size() < used) begin
				pick = $urandom_range(depth.size() - 1);
				if (depth[pick] < MAX_BITS) begin
					d = depth[pick] + 1;
					depth[pick] = d;
					depth.push_back(d);
				end
			end
		end
		foreach (perm[i]) perm[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			pick = $urandom_range(i);
			tmp = perm[i];
			perm[i] = perm[pick];
			perm[pick] = tmp;
		end
		foreach (lens[i]) lens[i] = 0;
		for (int i = 0; i < used; i++) lens[perm[i]] = depth[i];
		if (broken) begin
			repeat ($urandom_range(1, 3)) begin
				pick = $urandom_range(n - 1);
				case ($urandom_range(3))
					0: lens[pick] = $urandom_range(255);
					1: lens[pick] = $urandom_range(16, 17);
					2: lens[pick] = (lens[pick] > 1) ? lens[pick] - 1 : 1;
					default: lens[pick] = 0;
				endcase
			end
		end
		for (int i = 0; i < n; i++)
			send(F_ENTRY, lens[i][7:0], i == n - 1, 1'($urandom_range(1)));
	endtask

	// Random code bits, now and then an end-of-input mark or an unused code.
	task automatic send_bits(input int nb);
		int r;
		repeat (nb) begin
			r = $urandom_range(99);
			if (r < 5)
				send(F_END, 8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else if (r < 7)
				send(F_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			else
				send(F_BIT, 8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	// Directed rows. Results are typed in for every row that gives one; rows
	// without a typed result give none.
	row_t dir_rows[] = '{
		'{F_BIT,    8'd0,   1'b0, 1'b1, 1'b1, '{ST_NO_TABLE, 9'd0, 4'd0}},
		'{F_END,    8'd0,   1'b0, 1'b0, 1'b0, '0},
		'{F_ENTRY,  8'd16,  1'b1, 1'b0, 1'b1, '{ST_BAD_LEN, 9'd0, 4'd0}},
		'{F_BIT,    8'd0,   1'b0, 1'b0, 1'b1, '{ST_NO_TABLE, 9'd0, 4'd0}},
		'{F_ENTRY,  8'd255, 1'b1, 1'b1, 1'b1, '{ST_BAD_LEN, 9'd0, 4'd0}},
		'{F_ENTRY,  8'd0,   1'b1, 1'b0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
		'{F_BIT,    8'd0,   1'b0, 1'b1, 1'b0, '0},
		'{F_ENTRY,  8'd1,   1'b0, 1'b0, 1'b0, '0},
		'{F_ENTRY,  8'd1,   1'b1, 1'b0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
		'{F_BIT,    8'd0,   1'b0, 1'b0, 1'b1, '{ST_SYMBOL, 9'd0, 4'd1}},
		'{F_BIT,    8'd0,   1'b0, 1'b1, 1'b1, '{ST_SYMBOL, 9'd1, 4'd1}},
		'{F_ENTRY,  8'd1,   1'b0, 1'b0, 1'b0, '0},
		'{F_BIT,    8'd0,   1'b0, 1'b1, 1'b1, '{ST_NO_TABLE, 9'd0, 4'd0}},
		'{F_ENTRY,  8'd1,   1'b0, 1'b0, 1'b0, '0},
		'{F_ENTRY,  8'd1,   1'b1, 1'b0, 1'b1, '{ST_OVERSUB, 9'd0, 4'd0}},
		'{F_ENTRY,  8'd2,   1'b0, 1'b0, 1'b0, '0},
		'{F_ENTRY,  8'd2,   1'b1, 1'b0, 1'b1, '{ST_INCOMPLETE, 9'd0, 4'd0}},
		'{F_ENTRY,  8'd0,   1'b0, 1'b0, 1'b0, '0},
		'{F_ENTRY,  8'd15,  1'b1, 1'b0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
		'{F_BIT,    8'd0,   1'b0, 1'b1, 1'b0, '0},
		'{F_END,    8'd0,   1'b0, 1'b0, 1'b1, '{ST_OUT_OF_BITS, 9'd0, 4'd0}},
		'{F_UNUSED, 8'd0,   1'b0, 1'b0, 1'b0, '0},
		'{F_END,    8'd0,   1'b0, 1'b0, 1'b0, '0}
	};

	// The receiver stalls at the phase's rate.
	always @(posedge clk)
		out_item.ready <= ($urandom_range(99) >= stall_pct);

	// Every taken result is compared with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_item.valid && out_item.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d symbol %0d bits %0d",
						out_item.status, out_item.symbol, out_item.bits_used);
			end else begin
				want = expected_results.pop_front();
				if (out_item.status !== want.status || out_item.symbol !== want.symbol ||
					out_item.bits_used !== want.bits_used) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							want.status, want.symbol, want.bits_used, out_item.status,
							out_item.symbol, out_item.bits_used);
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int r, n, phase;
		bit too_many_done;
		in_item.valid = 1'b0;
		in_item.func = F_ENTRY;
		in_item.code_length = '0;
		in_item.last_entry = 1'b0;
		in_item.code_bit = 1'b0;
		foreach (len_cnt[k]) len_cnt[k] = 0;
		n_loaded = 0;
		bad_flags = 2'b00;
		table_ok = 1'b0;
		walk_clear();
		too_many_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].func, dir_rows[i].code_length, dir_rows[i].last_entry,
				dir_rows[i].code_bit, dir_rows[i].typed, dir_rows[i].res);
		drain();

		// Random part in four idling phases; the sender drains at each change.
		phase = 0;
		while (issued < N_ITEMS) begin
			if (issued * 4 / N_ITEMS != phase) begin
				phase = issued * 4 / N_ITEMS;
				drain();
			end
			case (phase)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 70; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 70; end
				default: begin idle_pct = 34; stall_pct = 34; end
			endcase
			r = $urandom_range(99);
			if (!too_many_done && phase == 1) begin
				// More entries than the store holds, then a bit without a table.
				too_many_done = 1'b1;
				for (int i = 0; i < MAX_SYMS + 1; i++)
					send(F_ENTRY, 8'($urandom_range(1, 9)), i == MAX_SYMS, 1'b0);
				send(F_BIT, 8'd0, 1'b0, 1'($urandom_range(1)));
			end else if (r < 75) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(30, 120) : $urandom_range(2, 20);
				load_table(n, $urandom_range(1, n), 1'b0);
				send_bits($urandom_range(5, 60));
			end else if (r < 88) begin
				n = $urandom_range(2, 16);
				load_table(n, $urandom_range(1, n), 1'b1);
				send_bits($urandom_range(1, 6));
			end else begin
				repeat ($urandom_range(1, 6))
					send(2'($urandom_range(3)), 8'($urandom_range(255)),
						1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end

		in_item.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/chtd_pkg.sv
rtl/chtd_if.sv
rtl/chtd_ctrl.sv
rtl/chtd_dp.sv
rtl/canonical_huffman_table_decoder.sv
rtl/chtd_chk.sv
test/canonical_huffman_table_decoder_test.sv
